### rtl/tscd_pkg.sv
`timescale 1ns / 1ps

package tscd_pkg;

    // search space and datapath width
    localparam int PRE_STEPS  = 8;
    localparam int POST_STEPS = 64;
    localparam int RATE_WIDTH = 32;

    // divider counters hold 1..STEPS
    localparam int PRE_W     = $clog2(PRE_STEPS + 1);
    localparam int POST_W    = $clog2(POST_STEPS + 1);
    localparam int DIVISOR_W = (PRE_W > POST_W) ? PRE_W : POST_W;
    localparam int BIT_CNT_W = $clog2(RATE_WIDTH);

    // result field widths
    localparam int PRE_DIV_W    = 3;
    localparam int POST_FIELD_W = 6;
    localparam int OUT_RATE_W   = 32;

    // stream packing
    localparam int IN_RATE_W  = 32;
    localparam int S_TDATA_W  = 2 * IN_RATE_W;
    localparam int M_FIELDS_W = PRE_DIV_W + POST_FIELD_W + 2 * OUT_RATE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_START,
        ST_PRE_WAIT,
        ST_POST_START,
        ST_POST_WAIT,
        ST_EVAL,
        ST_UPDATE,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic eval;
        logic update;
    } best_ctrl_t;

    typedef struct packed {
        logic [PRE_DIV_W-1:0]    pre;
        logic [POST_FIELD_W-1:0] post;
        logic [RATE_WIDTH-1:0]   dev;
        logic [RATE_WIDTH-1:0]   rate;
    } best_t;

endpackage

### rtl/tscd_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module tscd_div
    import tscd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [RATE_WIDTH-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [RATE_WIDTH-1:0] quotient
);

    logic [RATE_WIDTH-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [BIT_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  q_bit;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[RATE_WIDTH-1]};
        q_bit     = (rem_shift >= {1'b0, divisor});
        if (q_bit) begin
            rem_next = DIVISOR_W'(rem_shift - {1'b0, divisor});
        end else begin
            rem_next = DIVISOR_W'(rem_shift);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= BIT_CNT_W'(RATE_WIDTH - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[RATE_WIDTH-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == '0 && !start) |=> done_reg)
        else $error("divider missed its done pulse");

endmodule

### rtl/tscd_best.sv
`timescale 1ns / 1ps

// deviation of one candidate and tracking of the best pair
module tscd_best
    import tscd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  best_ctrl_t            ctrl,
    input  logic [RATE_WIDTH-1:0] got,
    input  logic [RATE_WIDTH-1:0] target,
    input  logic [PRE_W-1:0]      pre_idx,
    input  logic [POST_W-1:0]     post_idx,
    output best_t                 best
);

    logic                  have_reg;
    logic [RATE_WIDTH-1:0] diff_reg;
    best_t                 best_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (ctrl.clear) begin
            have_reg <= 1'b0;
        end else if (ctrl.update) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.eval) begin
            diff_reg <= (got > target) ? got - target : target - got;
        end
        // strictly smaller only, so the first of equal pairs stays
        if (ctrl.update && (!have_reg || diff_reg < best_reg.dev)) begin
            best_reg.pre  <= PRE_DIV_W'(pre_idx - 1'b1);
            best_reg.post <= POST_FIELD_W'(post_idx - 1'b1);
            best_reg.dev  <= diff_reg;
            best_reg.rate <= got;
        end
    end

    assign best = best_reg;

    a_dev_never_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.update && have_reg && !ctrl.clear) |=> best_reg.dev <= $past(best_reg.dev))
        else $error("best deviation increased");

    a_first_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.update && !have_reg) |=> (best_reg.dev == $past(diff_reg) && have_reg))
        else $error("first candidate not taken as best");

    a_ctrl_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl.clear, ctrl.eval, ctrl.update}))
        else $error("best tracker got overlapping commands");

endmodule

### rtl/two_stage_clock_divider_search.sv
`timescale 1ns / 1ps

// each pre-divider step runs one division, and each divider pair tried runs a division,
// a deviation and a compare, paced by the one-bit-per-cycle divider and its handshake
// the worst case is a full search of every pair, when no pair hits the target exactly
// one item in flight; the next one is taken once the result sits in the output register
// aresetn is synchronous, active low: clears the sequencer, divider and output valid
module two_stage_clock_divider_search
    import tscd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // src_rate[31:0], target_rate[63:32]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // pre_div[2:0], post_sel[8:3],
                                            // deviation[40:9], achieved_rate[72:41], zeros above
);

    state_t state_reg, state_next;

    // operands of the current item
    logic [RATE_WIDTH-1:0] parent_reg;
    logic [RATE_WIDTH-1:0] want_reg;
    // quotient after the pre-divider, and the candidate rate
    logic [RATE_WIDTH-1:0] stage_reg;
    logic [RATE_WIDTH-1:0] got_reg;
    // divider indices, each running 1..STEPS
    logic [PRE_W-1:0]      pre_reg;
    logic [POST_W-1:0]     post_reg;

    logic                  out_valid_reg;
    logic [M_FIELDS_W-1:0] out_data_reg;

    logic                  s_xfer;
    logic                  out_load;
    logic                  last_post;
    logic                  last_pre;

    // divider hookup
    logic                  div_start;
    logic                  div_sel_pre;
    logic [RATE_WIDTH-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [RATE_WIDTH-1:0] div_quotient;

    best_ctrl_t            best_ctrl;
    best_t                 best;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign last_post = (post_reg == POST_W'(POST_STEPS));
    assign last_pre  = (pre_reg == PRE_W'(PRE_STEPS));

    // sequencer: pre division, then for each post step a division, deviation and compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        div_start        = 1'b0;
        div_sel_pre      = 1'b0;
        best_ctrl.clear  = 1'b0;
        best_ctrl.eval   = 1'b0;
        best_ctrl.update = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    best_ctrl.clear = 1'b1;
                    state_next      = ST_PRE_START;
                end
            end
            ST_PRE_START: begin
                div_start   = 1'b1;
                div_sel_pre = 1'b1;
                state_next  = ST_PRE_WAIT;
            end
            ST_PRE_WAIT: begin
                // divisor is read every cycle of the division
                div_sel_pre = 1'b1;
                if (div_done) begin
                    state_next = ST_POST_START;
                end
            end
            ST_POST_START: begin
                div_start  = 1'b1;
                state_next = ST_POST_WAIT;
            end
            ST_POST_WAIT: begin
                if (div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                best_ctrl.eval = 1'b1;
                state_next     = ST_UPDATE;
            end
            ST_UPDATE: begin
                best_ctrl.update = 1'b1;
                state_next       = ST_NEXT;
            end
            ST_NEXT: begin
                // exact hit ends the search early
                if (best.dev == '0 || (last_post && last_pre)) begin
                    state_next = ST_OUT;
                end else if (last_post) begin
                    state_next = ST_PRE_START;
                end else begin
                    state_next = ST_POST_START;
                end
            end
            ST_OUT: begin
                // wait for the output register to be free
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // index counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg  <= PRE_W'(1);
            post_reg <= POST_W'(1);
        end else if (s_xfer) begin
            pre_reg  <= PRE_W'(1);
            post_reg <= POST_W'(1);
        end else if (state_reg == ST_NEXT) begin
            if (last_post) begin
                post_reg <= POST_W'(1);
                // stays at the last step once the search is over
                if (!last_pre) begin
                    pre_reg <= pre_reg + 1'b1;
                end
            end else begin
                post_reg <= post_reg + 1'b1;
            end
        end
    end

    // operand and intermediate registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            parent_reg <= s_tdata[IN_RATE_W-1:0];
            want_reg   <= s_tdata[2*IN_RATE_W-1:IN_RATE_W];
        end
        if (state_reg == ST_PRE_WAIT && div_done) begin
            stage_reg <= div_quotient;
        end
        if (state_reg == ST_POST_WAIT && div_done) begin
            got_reg <= div_quotient;
        end
    end

    assign div_dividend = div_sel_pre ? parent_reg : stage_reg;
    assign div_divisor  = div_sel_pre ? DIVISOR_W'(pre_reg) : DIVISOR_W'(post_reg);

    tscd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    tscd_best u_best (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (best_ctrl),
        .got      (got_reg),
        .target   (want_reg),
        .pre_idx  (pre_reg),
        .post_idx (post_reg),
        .best     (best)
    );

    // output register, keeps the result while the next item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {OUT_RATE_W'(best.rate), OUT_RATE_W'(best.dev),
                             best.post, best.pre};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_data_reg};

    a_post_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (post_reg != '0) && (post_reg <= POST_W'(POST_STEPS)))
        else $error("post-divider index out of range");

    a_pre_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pre_reg != '0) && (pre_reg <= PRE_W'(PRE_STEPS)))
        else $error("pre-divider index out of range");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("division issued while divider busy");

    a_valid_from_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tscd_pkg::*;

    // run control
    localparam int  CLK_HALF     = 4;
    localparam int  RESET_CYCLES = 2;
    localparam int  HOLD_CYCLES  = 50000;     // one long receiver hold-off
    localparam int  DRAIN_CYCLES = 20000;     // about one worst-case search
    localparam int  MAX_REPORTS  = 10;
    localparam int  RANDOM_ITEMS = 80;
    localparam longint CYCLE_LIMIT = 64'd10_000_000;

    localparam logic [RATE_WIDTH-1:0] RATE_MAX = '1;

    // one request and one chosen divider setting
    typedef struct packed {
        logic [RATE_WIDTH-1:0] parent;
        logic [RATE_WIDTH-1:0] target;
    } rate_req_t;

    typedef struct packed {
        logic [PRE_DIV_W-1:0]    pre;
        logic [POST_FIELD_W-1:0] post;
        logic [OUT_RATE_W-1:0]   dev;
        logic [OUT_RATE_W-1:0]   rate;
    } div_choice_t;

    // kinds of random request
    typedef enum int {
        REQ_EXACT,      // target reachable by some divider pair
        REQ_NEAR,       // a few Hz off a reachable rate
        REQ_ANY         // fully random
    } req_kind_t;

    // receiver back-pressure modes
    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // src_rate, target_rate
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // pre_div, post_sel, deviation, achieved_rate

    rate_req_t   pending_q[$];         // requests not yet offered
    div_choice_t divider_expect_q[$];  // predicted choices, oldest first

    int     mismatch_count = 0;
    longint cycle_count    = 0;

    // sender burst state
    int burst_left = 0;
    int gap_left   = 0;

    // receiver state
    ready_mode_t ready_mode  = READY_ALWAYS;
    int          phase_left  = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    int          rx_count    = 0;
    logic [15:0] ready_pattern = 16'hB3C5;

    two_stage_clock_divider_search DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // exhaustive best-fit search, pre-divider outer, post-divider inner;
    // first strictly better pair wins, an exact hit ends the search
    function automatic div_choice_t best_divider_pair(input logic [RATE_WIDTH-1:0] parent,
                                                      input logic [RATE_WIDTH-1:0] target);
        div_choice_t           best;
        logic [RATE_WIDTH-1:0] stage;
        logic [RATE_WIDTH-1:0] got;
        logic [RATE_WIDTH-1:0] dev;
        logic [RATE_WIDTH-1:0] best_dev;
        bit                    have;
        bit                    hit;
        best     = '0;
        best_dev = '0;
        have     = 1'b0;
        hit      = 1'b0;
        for (int p = 1; p <= PRE_STEPS && !hit; p++) begin
            stage = parent / p;
            for (int q = 1; q <= POST_STEPS && !hit; q++) begin
                got = stage / q;
                dev = (got > target) ? got - target : target - got;
                if (!have || dev < best_dev) begin
                    have      = 1'b1;
                    best_dev  = dev;
                    best.pre  = PRE_DIV_W'(p - 1);
                    best.post = POST_FIELD_W'(q - 1);
                    best.dev  = OUT_RATE_W'(dev);
                    best.rate = OUT_RATE_W'(got);
                end
                if (best_dev == 0) hit = 1'b1;
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(input string field_name, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", field_name, exp_v, got_v);
    endtask

    // stimulus: directed corners first, then random requests
    initial begin : stimulus
        rate_req_t req;
        req_kind_t kind;
        int        pre;
        int        post;
        // quick exact hits first so the long hold-off catches a busy sender
        pending_q.push_back('{parent: 32'd100, target: 32'd100});            // pair (1,1)
        pending_q.push_back('{parent: 32'd800_000_000, target: 32'd25_000_000});
        pending_q.push_back('{parent: 32'd24_000_000, target: 32'd375_000});  // last post step
        pending_q.push_back('{parent: 32'd10, target: 32'd3});
        pending_q.push_back('{parent: RATE_MAX, target: RATE_MAX});
        pending_q.push_back('{parent: 32'd1, target: 32'd1});
        pending_q.push_back('{parent: 32'd640, target: 32'd1});              // exact hit only with a large divider pair
        pending_q.push_back('{parent: 32'd1_000_000_000, target: 32'd125_000_000});
        // zero parent rate: every pair gives zero
        pending_q.push_back('{parent: 32'd0, target: 32'd0});
        pending_q.push_back('{parent: 32'd0, target: RATE_MAX});
        pending_q.push_back('{parent: 32'd0, target: 32'd12345});
        // zero target: smallest reachable rate wins
        pending_q.push_back('{parent: RATE_MAX, target: 32'd0});
        pending_q.push_back('{parent: 32'd24_000_000, target: 32'd0});
        pending_q.push_back('{parent: 32'd1, target: 32'd0});
        // ties: equal deviation later in the search must not replace the best
        pending_q.push_back('{parent: 32'd10, target: 32'd4});
        pending_q.push_back('{parent: 32'd1000, target: 32'd7});
        // no exact hit: full search
        pending_q.push_back('{parent: 32'd24_000_000, target: 32'd1});
        pending_q.push_back('{parent: 32'd1, target: RATE_MAX});
        pending_q.push_back('{parent: RATE_MAX, target: 32'd1});
        pending_q.push_back('{parent: 32'h8000_0000, target: 32'h7FFF_FFFF});
        pending_q.push_back('{parent: 32'd27_000_000, target: 32'd33_333_333});

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 3))
                0:       req.parent = $urandom_range(0, 5000);
                1:       req.parent = $urandom_range(1_000_000, 1_000_000_000);
                default: req.parent = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0, 1:    kind = REQ_EXACT;
                2:       kind = REQ_NEAR;
                default: kind = REQ_ANY;
            endcase
            pre  = $urandom_range(1, PRE_STEPS);
            post = $urandom_range(1, POST_STEPS);
            case (kind)
                REQ_EXACT: req.target = (req.parent / pre) / post;
                REQ_NEAR:  req.target = (req.parent / pre) / post + $urandom_range(0, 6) - 3;
                default:   req.target = $urandom;
            endcase
            pending_q.push_back(req);
        end
    end

    // reset once, then wait for everything to drain
    initial begin : run_control
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || divider_expect_q.size() != 0)
            @(posedge aclk);
        // catch any stray extra result
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // sender: bursts of requests with random gaps, valid held until the transfer
    always @(posedge aclk) begin : sender
        rate_req_t nxt;
        bit        holding;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            holding = s_tvalid;
            if (s_tvalid && s_tready) begin
                // accepted transfer: predict its result now
                divider_expect_q.push_back(best_divider_pair(s_tdata[IN_RATE_W-1:0],
                                                             s_tdata[IN_RATE_W +: IN_RATE_W]));
                holding = 1'b0;
                if (burst_left > 0) burst_left--;
                // end of burst: pick a gap, sometimes none at all
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    if (burst_left == 0) burst_left = $urandom_range(1, 12);
                    nxt     = pending_q.pop_front();
                    s_tdata <= {nxt.target, nxt.parent};
                    holding = 1'b1;
                end
            end
            // single nonblocking write so back-to-back valid stays high
            s_tvalid <= holding;
        end
    end

    // receiver: changing stall modes plus one long hold-off
    always @(posedge aclk) begin : receiver
        bit ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) rx_count++;
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (!hold_done && rx_count >= 3) begin
                // long hold-off: block fills up and stalls its input
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES;
                ready_next = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       ready_mode = READY_ALWAYS;
                        1:       ready_mode = READY_RANDOM;
                        default: ready_mode = READY_PATTERN;
                    endcase
                    phase_left = $urandom_range(16, 600);
                end else begin
                    phase_left--;
                end
                ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
                case (ready_mode)
                    READY_ALWAYS: ready_next = 1'b1;
                    READY_RANDOM: ready_next = ($urandom_range(0, 3) != 0);
                    default:      ready_next = ready_pattern[0];
                endcase
            end
            m_tready <= ready_next;
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : monitor
        div_choice_t want;
        div_choice_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.pre  = m_tdata[PRE_DIV_W-1:0];
            seen.post = m_tdata[PRE_DIV_W +: POST_FIELD_W];
            seen.dev  = m_tdata[PRE_DIV_W + POST_FIELD_W +: OUT_RATE_W];
            seen.rate = m_tdata[PRE_DIV_W + POST_FIELD_W + OUT_RATE_W +: OUT_RATE_W];
            if (divider_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result with no request pending: pre %0d post %0d dev %0d rate %0d",
                             seen.pre, seen.post, seen.dev, seen.rate);
            end else begin
                want = divider_expect_q.pop_front();
                if (seen.pre != want.pre)
                    report_mismatch("pre_div", 64'(want.pre), 64'(seen.pre));
                if (seen.post != want.post)
                    report_mismatch("post divider", 64'(want.post), 64'(seen.post));
                if (seen.dev != want.dev)
                    report_mismatch("deviation", 64'(want.dev), 64'(seen.dev));
                if (seen.rate != want.rate)
                    report_mismatch("achieved_rate", 64'(want.rate), 64'(seen.rate));
            end
        end
    end

endmodule
